// ===== rtl/bblf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the box blur line filter.
// Used by every module of the block; depends on nothing.
package bblf_pkg;

    localparam int PIX_W      = 8;
    localparam int RAD_W      = 6;
    localparam int MAX_RADIUS = 63;
    localparam int RING_AW    = RAD_W + 1;
    localparam int RING_DEPTH = 2 ** RING_AW;
    localparam int POS_W      = RAD_W + 2;
    localparam int POS_CAP    = 2 * MAX_RADIUS + 2;
    localparam int SUM_W      = 15;
    localparam int REM_W      = SUM_W + 2;
    localparam int STEP_W     = $clog2(PIX_W);

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             last_in_line;
    } bblf_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_out;
    } bblf_out_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic [POS_W-1:0] pos;
        logic [RAD_W-1:0] rad;
        logic             rebuild;
    } bblf_cmd_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [RAD_W-1:0] rad;
    } bblf_div_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quo;
    } bblf_div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SLIDE,
        ST_REBUILD,
        ST_LAGCHK,
        ST_DIV,
        ST_PUSH,
        ST_STEP
    } bblf_state_t;

endpackage

// ===== rtl/bblf_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts pixels, tracks the position in the line and holds the radius register.
// Depends on bblf_pkg.
module bblf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bblf_pkg::bblf_in_t            s_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bblf_pkg::RAD_W-1:0]    cfg_data,
    output logic                          push,
    output bblf_pkg::bblf_cmd_t           cmd,
    input  logic                          full
);
    import bblf_pkg::*;

    logic [RAD_W-1:0] radius_reg, radius_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             rebuild_reg, rebuild_next;
    logic [RAD_W-1:0] rad_clamped;
    logic             accept;

    assign s_ready   = !full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && !full;
    assign push      = accept;

    assign rad_clamped = (radius_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_reg;

    always_comb begin
        cmd.pixel   = s_data.pixel_in;
        cmd.last    = s_data.last_in_line;
        cmd.pos     = pos_reg;
        cmd.rad     = rad_clamped;
        cmd.rebuild = rebuild_reg;
    end

    always_comb begin
        radius_next  = radius_reg;
        pos_next     = pos_reg;
        rebuild_next = rebuild_reg;
        if (accept) begin
            rebuild_next = 1'b0;
            if (s_data.last_in_line) begin
                pos_next = '0;
            end else if (pos_reg < POS_W'(POS_CAP)) begin
                pos_next = pos_reg + 1'b1;
            end
        end
        if (cfg_valid) begin
            radius_next  = cfg_data;
            rebuild_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= RAD_W'(1);
            pos_reg     <= '0;
            rebuild_reg <= 1'b0;
        end else begin
            radius_reg  <= radius_next;
            pos_reg     <= pos_next;
            rebuild_reg <= rebuild_next;
        end
    end

endmodule

// ===== rtl/bblf_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the front end and the back end.
// Depends on bblf_pkg.
module bblf_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bblf_pkg::bblf_cmd_t push_data,
    output logic                full,
    input  logic                pop,
    output bblf_pkg::bblf_cmd_t pop_data,
    output logic                empty
);
    import bblf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bblf_cmd_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/bblf_div.sv =====
`timescale 1ns / 1ps
// Restoring divider that turns a window sum into its rounded mean, one quotient bit per cycle.
// Depends on bblf_pkg.
module bblf_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bblf_pkg::bblf_div_req_t req,
    output bblf_pkg::bblf_div_rsp_t rsp
);
    import bblf_pkg::*;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  dvs_reg, dvs_next;
    logic [PIX_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RAD_W:0]    den;
    logic [RAD_W+1:0]  den2;
    logic              ge;

    // The rounded mean is (2*sum + D) / (2*D) with D = 2*radius + 1.
    assign den  = {req.rad, 1'b1};
    assign den2 = {req.rad, 2'b10};
    assign ge   = rem_reg >= REM_W'(dvs_reg);

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = (REM_W'(req.sum) << 1) + REM_W'(den);
            dvs_next  = SUM_W'(den2) << (PIX_W - 1);
            step_next = STEP_W'(PIX_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? rem_reg - REM_W'(dvs_reg) : rem_reg;
            dvs_next  = dvs_reg >> 1;
            quo_next  = {quo_reg[PIX_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== rtl/bblf_back.sv =====
`timescale 1ns / 1ps
// Back end: pixel ring memory, running window sum, flush sequencer and output register.
// Depends on bblf_pkg; works with bblf_div.
module bblf_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    empty,
    output logic                    pop,
    input  bblf_pkg::bblf_cmd_t     cmd,
    output bblf_pkg::bblf_div_req_t div_req,
    input  bblf_pkg::bblf_div_rsp_t div_rsp,
    output logic                    m_valid,
    input  logic                    m_ready,
    output bblf_pkg::bblf_out_t     m_data
);
    import bblf_pkg::*;

    bblf_state_t        state_reg, state_next;
    bblf_cmd_t          cmd_reg, cmd_next;
    logic [PIX_W-1:0]   first_reg, first_next;
    logic [RING_AW-1:0] head_reg, head_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [RAD_W-1:0]   lag_reg, lag_next;
    logic [RING_AW-1:0] cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    bblf_out_t          out_data_reg, out_data_next;

    logic [PIX_W-1:0]   ring_mem [RING_DEPTH];
    logic [PIX_W-1:0]   rd_q_reg;
    logic               mem_we;
    logic [RING_AW-1:0] mem_wa, mem_ra;

    logic [RING_AW-1:0] head_inc, span_odd, far_back, in_span, rb_limit;
    logic               slot_free, emit_ok, rebuild_done;
    logic [PIX_W-1:0]   add_val, sub_val;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   init_sum;

    assign head_inc     = head_reg + 1'b1;
    assign span_odd     = {cmd_reg.rad, 1'b1};
    assign in_span      = {cmd.rad, 1'b1};
    assign far_back     = RING_AW'(lag_reg) + RING_AW'(cmd_reg.rad);
    assign rb_limit     = {cmd_reg.rad, 1'b0};
    assign rebuild_done = cnt_reg > rb_limit;
    assign slot_free    = !out_valid_reg || m_ready;
    assign emit_ok      = cmd_reg.last ? (POS_W'(lag_reg) <= cmd_reg.pos)
                                       : (cmd_reg.pos >= POS_W'(cmd_reg.rad));
    assign init_sum     = SUM_W'(span_odd) * SUM_W'(first_reg);

    always_comb begin
        add_val = cmd_reg.pixel;
        sub_val = '0;
        case (state_reg)
            ST_SLIDE: begin
                sub_val = (cmd_reg.pos <= POS_W'(span_odd)) ? first_reg : rd_q_reg;
            end
            ST_STEP: begin
                sub_val = (POS_W'(far_back) >= cmd_reg.pos) ? first_reg : rd_q_reg;
            end
            ST_REBUILD: begin
                add_val = (POS_W'(cnt_reg) >= cmd_reg.pos) ? first_reg : rd_q_reg;
            end
            default: begin
                sub_val = '0;
            end
        endcase
    end

    assign sum_wide = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(add_val) - (SUM_W + 1)'(sub_val);

    always_comb begin
        case (state_reg)
            ST_IDLE: begin
                mem_ra = head_inc - (cmd.rebuild ? RING_AW'(1) : in_span);
            end
            ST_REBUILD: begin
                mem_ra = head_reg - (cnt_reg + 1'b1);
            end
            default: begin
                mem_ra = head_reg - far_back;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!empty) begin
                    if (cmd.pos == '0) begin
                        state_next = ST_INIT;
                    end else if (cmd.rebuild) begin
                        state_next = ST_REBUILD;
                    end else begin
                        state_next = ST_SLIDE;
                    end
                end
            end
            ST_INIT: begin
                state_next = ST_LAGCHK;
            end
            ST_SLIDE: begin
                state_next = ST_LAGCHK;
            end
            ST_REBUILD: begin
                if (rebuild_done) begin
                    state_next = ST_LAGCHK;
                end
            end
            ST_LAGCHK: begin
                if (emit_ok) begin
                    state_next = ST_DIV;
                end else if (cmd_reg.last) begin
                    state_next = ST_STEP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (slot_free) begin
                    state_next = (cmd_reg.last && lag_reg != '0) ? ST_STEP : ST_IDLE;
                end
            end
            ST_STEP: begin
                state_next = ST_LAGCHK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = head_inc;
        cmd_next       = cmd_reg;
        first_next     = first_reg;
        head_next      = head_reg;
        sum_next       = sum_reg;
        lag_next       = lag_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        div_req.start  = 1'b0;
        div_req.sum    = sum_reg;
        div_req.rad    = cmd_reg.rad;
        case (state_reg)
            ST_IDLE: begin
                if (!empty) begin
                    pop       = 1'b1;
                    mem_we    = 1'b1;
                    cmd_next  = cmd;
                    head_next = head_inc;
                    lag_next  = cmd.rad;
                    cnt_next  = RING_AW'(1);
                    if (cmd.pos == '0) begin
                        first_next = cmd.pixel;
                    end
                    if (cmd.rebuild) begin
                        sum_next = SUM_W'(cmd.pixel);
                    end
                end
            end
            ST_INIT: begin
                sum_next = init_sum;
            end
            ST_SLIDE: begin
                sum_next = sum_wide[SUM_W-1:0];
            end
            ST_REBUILD: begin
                if (!rebuild_done) begin
                    sum_next = sum_wide[SUM_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LAGCHK: begin
                div_req.start = emit_ok;
            end
            ST_PUSH: begin
                if (slot_free) begin
                    out_valid_next          = 1'b1;
                    out_data_next.pixel_out = div_rsp.quo;
                    out_data_next.last_out  = cmd_reg.last && (lag_reg == '0);
                end
            end
            ST_STEP: begin
                sum_next = sum_wide[SUM_W-1:0];
                lag_next = lag_reg - 1'b1;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_wa] <= cmd.pixel;
        end
        rd_q_reg <= ring_mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        first_reg    <= first_next;
        sum_reg      <= sum_next;
        lag_reg      <= lag_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== rtl/box_blur_line_filter.sv =====
`timescale 1ns / 1ps
// Top level of the box blur line filter: front end, request queue, back end and divider.
// Depends on bblf_pkg, bblf_front, bblf_queue, bblf_div and bblf_back.
//
// Pixels of a line enter on the s_ channel, the last one flagged by last_in_line.
// Blurred pixels leave on the m_ channel in the same order, the final one of each
// line flagged by last_out. The cfg_ channel writes the radius; it is always ready
// and must only be written while no pixel is in flight.
// The front end takes one pixel per cycle into a queue of QUEUE_DEPTH requests, so
// s_ready drops only when that queue is full.
// For a pixel that yields a result, the back end takes it, updates the running window
// sum and checks the lag, then runs the eight-step divider and loads the output register.
// It finishes one pixel before it takes the next from the queue. A pixel that yields no
// result returns to idle after the lag check. The last pixel of a line yields up to
// radius+1 results; each one after the first steps the window back, checks the lag again
// and runs the divider. A pixel in mid-line after a radius write first rebuilds the sum.
// A stalled m_ready holds the result in the output register; the back end then
// waits and the queue keeps taking pixels until it fills.
// Reset clears the queue, the line position and the output valid flag and sets the
// radius to 1; the ring memory needs no clearing.
module box_blur_line_filter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  bblf_pkg::bblf_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bblf_pkg::bblf_out_t        m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bblf_pkg::RAD_W-1:0] cfg_data
);
    import bblf_pkg::*;

    bblf_cmd_t     push_cmd, pop_cmd;
    logic          push, pop, full, empty;
    bblf_div_req_t div_req;
    bblf_div_rsp_t div_rsp;

    bblf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .cmd       (push_cmd),
        .full      (full)
    );

    bblf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .empty     (empty)
    );

    bblf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    bblf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (empty),
        .pop     (pop),
        .cmd     (pop_cmd),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/bblf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the box blur line filter, bound to the top level.
// Depends on bblf_pkg and box_blur_line_filter.
module bblf_port_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input bblf_pkg::bblf_in_t         s_data,
    input logic                       m_valid,
    input logic                       m_ready,
    input bblf_pkg::bblf_out_t        m_data
);
    import bblf_pkg::*;

    logic [7:0] pend_reg, pend_next;
    logic       in_last, out_last;

    assign in_last  = s_valid && s_ready && s_data.last_in_line;
    assign out_last = m_valid && m_ready && m_data.last_out;

    always_comb begin
        pend_next = pend_reg;
        if (in_last && !out_last) begin
            pend_next = pend_reg + 1'b1;
        end else if (out_last && !in_last) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result changed or dropped while stalled.");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("Input not ready right after reset.");

    a_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_out |-> pend_reg != '0)
        else $error("End of line emitted without a pending input line.");

endmodule

bind box_blur_line_filter bblf_port_checker u_bblf_port_checker (.*);

// ===== tb/bblf_checker.sv =====
`timescale 1ns / 1ps
// Checker for the box blur line filter: watches the pixel, result and radius channels.
// It predicts each blurred pixel from the accepted pixels and compares the results.
// Depends on bblf_pkg.
module bblf_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  bblf_pkg::bblf_in_t         s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  bblf_pkg::bblf_out_t        m_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [bblf_pkg::RAD_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending_results
);
    import bblf_pkg::*;

    localparam int LINE_CAP = 4095;

    logic [PIX_W-1:0]   ring [RING_DEPTH];
    logic [RING_AW-1:0] head;
    logic [PIX_W-1:0]   first_pix;
    int                 line_pos;
    logic [RAD_W-1:0]   radius;
    bblf_out_t          blurred_q [$];
    int                 results_seen;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [PIX_W-1:0] box_mean(input int lag, input int n, input int r);
        int acc;
        int back;
        int den;
        acc = 0;
        den = 2 * r + 1;
        for (int d = -r; d <= r; d++) begin
            back = (lag - d < 0) ? 0 : lag - d;
            if (back > n) begin
                acc += first_pix;
            end else begin
                acc += ring[head - RING_AW'(back)];
            end
        end
        return PIX_W'((2 * acc + den) / (2 * den));
    endfunction

    task automatic predict_pixel(input bblf_in_t px);
        int        r;
        int        n;
        int        lag;
        bblf_out_t res;
        r = int'(radius);
        n = line_pos;
        if (n == 0) begin
            first_pix = px.pixel_in;
        end
        head = head + 1'b1;
        ring[head] = px.pixel_in;
        if (px.last_in_line) begin
            lag = (n < r) ? n : r;
            while (lag >= 0) begin
                res.pixel_out = box_mean(lag, n, r);
                res.last_out  = (lag == 0);
                blurred_q.push_back(res);
                lag--;
            end
            line_pos = 0;
        end else begin
            if (n >= r) begin
                res.pixel_out = box_mean(r, n, r);
                res.last_out  = 1'b0;
                blurred_q.push_back(res);
            end
            if (n < LINE_CAP) begin
                line_pos = n + 1;
            end
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        bblf_out_t want;
        if (!aresetn) begin
            head         = '0;
            first_pix    = '0;
            line_pos     = 0;
            radius       = RAD_W'(1);
            results_seen = 0;
            blurred_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                radius = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (blurred_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d (pixel %0d, last %0b) not expected",
                        results_seen, m_data.pixel_out, m_data.last_out));
                end else begin
                    want = blurred_q.pop_front();
                    if (m_data.pixel_out !== want.pixel_out) begin
                        report_mismatch($sformatf("result %0d: pixel_out %0d, expected %0d",
                            results_seen, m_data.pixel_out, want.pixel_out));
                    end
                    if (m_data.last_out !== want.last_out) begin
                        report_mismatch($sformatf("result %0d: last_out %0b, expected %0b",
                            results_seen, m_data.last_out, want.last_out));
                    end
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                predict_pixel(s_data);
            end
        end
        pending_results <= blurred_q.size();
    end

endmodule

// ===== tb/tb_box_blur_line_filter.sv =====
`timescale 1ns / 1ps
// Testbench top for the box blur line filter: clock, reset, pixel and radius stimulus.
// Depends on bblf_pkg, box_blur_line_filter and bblf_checker, which gives the failure count.
module tb_box_blur_line_filter;
    import bblf_pkg::*;

    localparam int RANDOM_ITEMS  = 420;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    bblf_in_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    bblf_out_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [RAD_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending_results;
    int   pixels_sent   = 0;
    int   hold_requests = 0;
    int   holds_served  = 0;
    logic idle_on       = 1'b1;

    box_blur_line_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bblf_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // The sink stalls at random, and serves each long hold-off request from the sender.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= !idle_on || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
        s_data  <= '{pixel_in: pix, last_in_line: last};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        if (idle_on && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic send_line(input int len);
        for (int i = 0; i < len; i++) begin
            send_pixel(pick_pixel(), i == len - 1);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radius(input logic [RAD_W-1:0] rad);
        drain_results();
        cfg_data  <= rad;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int               phase;
        int               len;
        int               directed_items;
        logic [RAD_W-1:0] rad;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Radius is still at its reset value of one here.
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b1);

        write_radius('0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h80, 1'b1);

        // A line much shorter than the window clamps at both ends.
        write_radius(RAD_W'(MAX_RADIUS));
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h01, 1'b1);

        // The radius changes in the middle of a line.
        write_radius(RAD_W'(2));
        send_pixel(8'h10, 1'b0);
        send_pixel(8'hF0, 1'b0);
        send_pixel(8'h33, 1'b0);
        write_radius(RAD_W'(1));
        send_pixel(8'hC8, 1'b0);
        send_pixel(8'h05, 1'b0);
        send_pixel(8'h7F, 1'b1);

        directed_items = pixels_sent;
        phase = 0;
        while (pixels_sent < directed_items + RANDOM_ITEMS) begin
            case (phase % 6)
                0: begin
                    rad = RAD_W'(MAX_RADIUS);
                end
                1: begin
                    rad = '0;
                end
                default: begin
                    rad = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom_range(0, MAX_RADIUS))
                                                      : RAD_W'($urandom_range(1, 8));
                end
            endcase
            write_radius(rad);
            idle_on <= (phase != 2);
            if (phase == 3) begin
                hold_requests <= hold_requests + 1;
                send_line(40);
            end
            if (phase == 4) begin
                send_line(160);
            end
            repeat ($urandom_range(3, 6)) begin
                if ($urandom_range(0, 7) == 0) begin
                    len = $urandom_range(1, 2 * int'(rad) + 4);
                end else begin
                    len = $urandom_range(1, (2 * int'(rad) + 4 < 24) ? 2 * int'(rad) + 4 : 24);
                end
                send_line(len);
            end
            phase++;
        end

        drain_results();
        if (fail_count == 0 && pending_results == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
